### rtl/mtmc_pkg.sv
// Package for masked_tile_match_count.
// Holds controller/datapath interface structs and fixed codes; no dependencies.
package mtmc_pkg;

    localparam int PIX_W    = 25;
    localparam int FLAG_BIT = 24;
    localparam int RAW_W    = 32;
    localparam int COORD_W  = 7;
    localparam int CFG_W    = 8;
    localparam int COUNT_W  = 7;

    localparam logic ACT_WRITE   = 1'b0;
    localparam logic ACT_COMPARE = 1'b1;

    localparam logic CFG_FRAME_WIDTH  = 1'b0;
    localparam logic CFG_FRAME_HEIGHT = 1'b1;

    localparam logic [CFG_W-1:0] FRAME_SIZE_RST = 8'd128;

    typedef struct packed {
        logic wr;
        logic load;
        logic step;
    } t_cmd;

    typedef struct packed {
        logic last;
    } t_status;

endpackage

### rtl/mtmc_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module mtmc_ram #(
    parameter int WIDTH = 25,
    parameter int DEPTH = 16384
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/mtmc_ctrl.sv
// Controller for masked_tile_match_count: sequences the tile walk.
// Depends on mtmc_pkg.
module mtmc_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic             i_action,
    input  mtmc_pkg::t_status i_status,
    output mtmc_pkg::t_cmd   o_cmd,
    output logic             o_busy,
    output logic             o_valid
);
    import mtmc_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_WAIT
    } t_state;

    t_state r_state, n_state;
    logic   r_valid, n_valid;
    logic   req;

    assign o_busy = (r_state != S_IDLE);
    assign req    = i_start && !o_busy;

    assign o_cmd.wr   = req && (i_action == ACT_WRITE);
    assign o_cmd.load = req && (i_action == ACT_COMPARE);
    assign o_cmd.step = (r_state == S_RUN);

    always_comb begin
        n_state = r_state;
        n_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (o_cmd.load) begin
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                if (i_status.last) begin
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                n_state = S_IDLE;
                n_valid = 1'b1;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    assign o_valid = r_valid;

endmodule

### rtl/mtmc_dp.sv
// Datapath for masked_tile_match_count: config registers, corner clamp,
// tile counters, two frame memory copies and the match accumulator.
// Depends on mtmc_pkg and mtmc_ram.
module mtmc_dp #(
    parameter int MAX_WIDTH   = 128,
    parameter int MAX_HEIGHT  = 128,
    parameter int TILE_WIDTH  = 8,
    parameter int TILE_HEIGHT = 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic                           i_cfg_idx,
    input  logic [mtmc_pkg::CFG_W-1:0]     i_cfg_data,
    input  mtmc_pkg::t_cmd                 i_cmd,
    input  logic [mtmc_pkg::COORD_W-1:0]   i_pixel_x,
    input  logic [mtmc_pkg::COORD_W-1:0]   i_pixel_y,
    input  logic [mtmc_pkg::RAW_W-1:0]     i_pixel_value,
    input  logic [mtmc_pkg::COORD_W-1:0]   i_target_x,
    input  logic [mtmc_pkg::COORD_W-1:0]   i_target_y,
    input  logic [mtmc_pkg::COORD_W-1:0]   i_src_x,
    input  logic [mtmc_pkg::COORD_W-1:0]   i_src_y,
    output mtmc_pkg::t_status              o_status,
    output logic [mtmc_pkg::COUNT_W-1:0]   o_match_count
);
    import mtmc_pkg::*;

    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int YW    = $clog2(MAX_HEIGHT);
    localparam int AW    = XW + YW;
    localparam int CW    = $clog2(TILE_WIDTH);
    localparam int RW    = $clog2(TILE_HEIGHT);
    localparam int SXW   = $clog2(MAX_WIDTH + 1);
    localparam int SYW   = $clog2(MAX_HEIGHT + 1);
    localparam int EXW   = (SXW > CFG_W) ? SXW : CFG_W;
    localparam int EYW   = (SYW > CFG_W) ? SYW : CFG_W;
    localparam int NW    = $clog2(TILE_WIDTH * TILE_HEIGHT + 1);
    localparam int OW    = (NW > COUNT_W) ? NW : COUNT_W;
    localparam int HALFX = TILE_WIDTH / 2;
    localparam int HALFY = TILE_HEIGHT / 2;

    logic [CFG_W-1:0] r_frame_w, r_frame_h;
    logic [XW-1:0]    r_ax, r_bx;
    logic [YW-1:0]    r_ay, r_by;
    logic [CW-1:0]    r_col;
    logic [RW-1:0]    r_row;
    logic             r_rd_vld;
    logic             r_src_masked;
    logic [NW-1:0]    r_count;

    logic [EXW-1:0]   w_eff, ax_c, bx_c;
    logic [EYW-1:0]   h_eff, ay_c, by_c;
    logic             wr_en;
    logic [AW-1:0]    waddr, taddr, saddr;
    logic [PIX_W-1:0] wdata, tpix, spix;
    logic             col_last, row_last;
    logic [OW-1:0]    count_ext;

    // Effective frame size and clamped tile corners
    always_comb begin
        logic [EXW-1:0] wr;
        logic [EYW-1:0] hr;
        wr = EXW'(r_frame_w);
        hr = EYW'(r_frame_h);
        w_eff = (wr > EXW'(MAX_WIDTH)) ? EXW'(MAX_WIDTH) : wr;
        if (w_eff < EXW'(TILE_WIDTH)) w_eff = EXW'(TILE_WIDTH);
        h_eff = (hr > EYW'(MAX_HEIGHT)) ? EYW'(MAX_HEIGHT) : hr;
        if (h_eff < EYW'(TILE_HEIGHT)) h_eff = EYW'(TILE_HEIGHT);
    end

    function automatic logic [EXW-1:0] clamp_x(input logic [COORD_W-1:0] centre,
                                               input logic [EXW-1:0] size);
        logic [EXW-1:0] c;
        c = (EXW'(centre) >= EXW'(HALFX)) ? EXW'(centre) - EXW'(HALFX) : '0;
        if (c + EXW'(TILE_WIDTH) > size) c = size - EXW'(TILE_WIDTH);
        return c;
    endfunction

    function automatic logic [EYW-1:0] clamp_y(input logic [COORD_W-1:0] centre,
                                               input logic [EYW-1:0] size);
        logic [EYW-1:0] c;
        c = (EYW'(centre) >= EYW'(HALFY)) ? EYW'(centre) - EYW'(HALFY) : '0;
        if (c + EYW'(TILE_HEIGHT) > size) c = size - EYW'(TILE_HEIGHT);
        return c;
    endfunction

    assign ax_c = clamp_x(i_target_x, w_eff);
    assign bx_c = clamp_x(i_src_x, w_eff);
    assign ay_c = clamp_y(i_target_y, h_eff);
    assign by_c = clamp_y(i_src_y, h_eff);

    // Pixel write
    assign wr_en = i_cmd.wr
                && (EXW'(i_pixel_x) < EXW'(MAX_WIDTH))
                && (EYW'(i_pixel_y) < EYW'(MAX_HEIGHT));
    assign waddr = {YW'(i_pixel_y), XW'(i_pixel_x)};
    assign wdata = {(i_pixel_value[RAW_W-1:PIX_W-1] != '0), i_pixel_value[PIX_W-2:0]};

    // Read addresses for the current tile position
    assign taddr = {r_ay + YW'(r_row), r_ax + XW'(r_col)};
    assign saddr = {r_by + YW'(r_row), r_bx + XW'(r_col)};

    mtmc_ram #(.WIDTH(PIX_W), .DEPTH(2 ** AW)) u_ram_tgt (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (taddr),
        .o_rdata (tpix)
    );

    mtmc_ram #(.WIDTH(PIX_W), .DEPTH(2 ** AW)) u_ram_src (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (saddr),
        .o_rdata (spix)
    );

    assign col_last      = (r_col == CW'(TILE_WIDTH - 1));
    assign row_last      = (r_row == RW'(TILE_HEIGHT - 1));
    assign o_status.last = col_last && row_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_w <= FRAME_SIZE_RST;
            r_frame_h <= FRAME_SIZE_RST;
            r_rd_vld  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_FRAME_WIDTH:  r_frame_w <= i_cfg_data;
                    CFG_FRAME_HEIGHT: r_frame_h <= i_cfg_data;
                    default:          r_frame_w <= r_frame_w;
                endcase
            end
            r_rd_vld <= i_cmd.step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_ax         <= XW'(ax_c);
            r_bx         <= XW'(bx_c);
            r_ay         <= YW'(ay_c);
            r_by         <= YW'(by_c);
            r_col        <= '0;
            r_row        <= '0;
            r_count      <= '0;
            r_src_masked <= 1'b0;
        end else begin
            if (i_cmd.step) begin
                if (col_last) begin
                    r_col <= '0;
                    r_row <= r_row + RW'(1);
                end else begin
                    r_col <= r_col + CW'(1);
                end
            end
            if (r_rd_vld) begin
                if (spix[FLAG_BIT]) begin
                    r_src_masked <= 1'b1;
                end else if (tpix[FLAG_BIT] || (tpix == spix)) begin
                    r_count <= r_count + NW'(1);
                end
            end
        end
    end

    assign count_ext     = OW'(r_count);
    assign o_match_count = r_src_masked ? '0 : count_ext[COUNT_W-1:0];

endmodule

### rtl/masked_tile_match_count.sv
// Top level of masked_tile_match_count: controller plus datapath.
// Depends on mtmc_pkg, mtmc_ctrl, mtmc_dp (and mtmc_ram through mtmc_dp).
//
// A write request (i_action = 0) stores one pixel at the accepting edge and
// leaves the block free the next cycle. A compare request (i_action = 1)
// walks the two tiles one pixel pair per cycle from two copies of the frame
// memory, so busy stays high through the walk and the wait state after it;
// o_valid then strobes o_match_count for one cycle, during which the next
// request is already taken. The result cannot be held off: capture it in
// the strobe cycle. Frame memory contents are undefined until written;
// read only written pixels.
module masked_tile_match_count #(
    parameter int MAX_WIDTH   = 128,
    parameter int MAX_HEIGHT  = 128,
    parameter int TILE_WIDTH  = 8,
    parameter int TILE_HEIGHT = 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic                           i_cfg_we,
    input  logic                           i_cfg_idx,
    input  logic [mtmc_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                           i_action,
    input  logic [mtmc_pkg::COORD_W-1:0]   i_pixel_x,
    input  logic [mtmc_pkg::COORD_W-1:0]   i_pixel_y,
    input  logic [mtmc_pkg::RAW_W-1:0]     i_pixel_value,
    input  logic [mtmc_pkg::COORD_W-1:0]   i_target_x,
    input  logic [mtmc_pkg::COORD_W-1:0]   i_target_y,
    input  logic [mtmc_pkg::COORD_W-1:0]   i_src_x,
    input  logic [mtmc_pkg::COORD_W-1:0]   i_src_y,
    output logic                           o_valid,
    output logic [mtmc_pkg::COUNT_W-1:0]   o_match_count
);
    import mtmc_pkg::*;

    t_cmd    cmd;
    t_status status;

    mtmc_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_action (i_action),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (busy),
        .o_valid  (o_valid)
    );

    mtmc_dp #(
        .MAX_WIDTH   (MAX_WIDTH),
        .MAX_HEIGHT  (MAX_HEIGHT),
        .TILE_WIDTH  (TILE_WIDTH),
        .TILE_HEIGHT (TILE_HEIGHT)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_cmd         (cmd),
        .i_pixel_x     (i_pixel_x),
        .i_pixel_y     (i_pixel_y),
        .i_pixel_value (i_pixel_value),
        .i_target_x    (i_target_x),
        .i_target_y    (i_target_y),
        .i_src_x       (i_src_x),
        .i_src_y       (i_src_y),
        .o_status      (status),
        .o_match_count (o_match_count)
    );

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps
// Testbench for masked_tile_match_count: pixel writes and tile compares, with a
// scoreboard class that predicts every match count. Depends on mtmc_pkg and the RTL.
module testbench;
    import mtmc_pkg::*;

    localparam int MAX_W       = 128;
    localparam int MAX_H       = 128;
    localparam int TILE_W      = 8;
    localparam int TILE_H      = 8;
    localparam int STORE_DEPTH = MAX_W * MAX_H;
    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int MAX_REPORTS = 10;
    localparam int DRAIN_CYCLES = 80;

    typedef struct packed {
        logic               action;
        logic [COORD_W-1:0] pixel_x;
        logic [COORD_W-1:0] pixel_y;
        logic [RAW_W-1:0]   pixel_value;
        logic [COORD_W-1:0] target_x;
        logic [COORD_W-1:0] target_y;
        logic [COORD_W-1:0] src_x;
        logic [COORD_W-1:0] src_y;
    } t_request;

    class t_tile_match_board;
        logic [PIX_W-1:0] frame [STORE_DEPTH];
        int unsigned      frame_w;
        int unsigned      frame_h;
        int unsigned      expected_counts [$];
        int unsigned      failures;

        function new();
            frame_w  = 128;
            frame_h  = 128;
            failures = 0;
        endfunction

        function void set_register(logic idx, logic [CFG_W-1:0] data);
            if (idx == CFG_FRAME_WIDTH) begin
                frame_w = data;
            end else begin
                frame_h = data;
            end
        endfunction

        function int unsigned pixel_index(int unsigned x, int unsigned y);
            return y * MAX_W + x;
        endfunction

        // center moved back by half a tile, tile kept inside the saturated frame
        function int unsigned tile_corner(int unsigned centre, bit vertical);
            int unsigned size;
            int unsigned lim;
            int unsigned tile;
            int unsigned c;
            size = vertical ? frame_h : frame_w;
            lim  = vertical ? MAX_H : MAX_W;
            tile = vertical ? TILE_H : TILE_W;
            if (size > lim) size = lim;
            if (size < tile) size = tile;
            c = (centre >= tile / 2) ? centre - tile / 2 : 0;
            if (c + tile > size) c = size - tile;
            return c;
        endfunction

        function int unsigned predict_match_count(t_request r);
            int unsigned      ax;
            int unsigned      ay;
            int unsigned      bx;
            int unsigned      by;
            int unsigned      count;
            logic [PIX_W-1:0] tp;
            logic [PIX_W-1:0] sp;
            ax = tile_corner(r.target_x, 1'b0);
            ay = tile_corner(r.target_y, 1'b1);
            bx = tile_corner(r.src_x, 1'b0);
            by = tile_corner(r.src_y, 1'b1);
            count = 0;
            for (int row = 0; row < TILE_H; row++) begin
                for (int col = 0; col < TILE_W; col++) begin
                    tp = frame[pixel_index(ax + col, ay + row)];
                    sp = frame[pixel_index(bx + col, by + row)];
                    if (sp[FLAG_BIT]) return 0;
                    if (tp[FLAG_BIT] || tp == sp) count++;
                end
            end
            return count;
        endfunction

        function void note_request(t_request r);
            if (r.action == ACT_WRITE) begin
                frame[pixel_index(r.pixel_x, r.pixel_y)] =
                    {|r.pixel_value[RAW_W-1:24], r.pixel_value[23:0]};
            end else begin
                expected_counts.push_back(predict_match_count(r));
            end
        endfunction

        function void check_result(logic [COUNT_W-1:0] got);
            int unsigned want;
            if (expected_counts.size() == 0) begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $display("match_count %0d with no compare pending", got);
            end else begin
                want = expected_counts.pop_front();
                if (got !== COUNT_W'(want)) begin
                    failures++;
                    if (failures <= MAX_REPORTS)
                        $display("match_count mismatch: expected %0d, got %0d", want, got);
                end
            end
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic               i_cfg_we;
    logic               i_cfg_idx;
    logic [CFG_W-1:0]   i_cfg_data;
    logic               i_action;
    logic [COORD_W-1:0] i_pixel_x;
    logic [COORD_W-1:0] i_pixel_y;
    logic [RAW_W-1:0]   i_pixel_value;
    logic [COORD_W-1:0] i_target_x;
    logic [COORD_W-1:0] i_target_y;
    logic [COORD_W-1:0] i_src_x;
    logic [COORD_W-1:0] i_src_y;
    logic               o_valid;
    logic [COUNT_W-1:0] o_match_count;

    t_tile_match_board board;
    bit              pix_written [STORE_DEPTH];
    logic [23:0]     palette [4];
    int unsigned     requests_sent;
    int unsigned     compares_sent;
    int unsigned     base_x;
    int unsigned     base_y;
    int unsigned     cycle_count = 0;
    bit              gapless;

    masked_tile_match_count dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_action      (i_action),
        .i_pixel_x     (i_pixel_x),
        .i_pixel_y     (i_pixel_y),
        .i_pixel_value (i_pixel_value),
        .i_target_x    (i_target_x),
        .i_target_y    (i_target_y),
        .i_src_x       (i_src_x),
        .i_src_y       (i_src_y),
        .o_valid       (o_valid),
        .o_match_count (o_match_count)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) board.check_result(o_match_count);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic send_request(input t_request r);
        int unsigned gap;
        if ($urandom_range(0, 39) == 0) gapless = !gapless;
        gap = gapless ? 0 : $urandom_range(0, 18);
        if (gap > 0) begin
            @(negedge i_clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_action      <= r.action;
        i_pixel_x     <= r.pixel_x;
        i_pixel_y     <= r.pixel_y;
        i_pixel_value <= r.pixel_value;
        i_target_x    <= r.target_x;
        i_target_y    <= r.target_y;
        i_src_x       <= r.src_x;
        i_src_y       <= r.src_y;
        start         <= 1'b1;
        do @(posedge i_clk); while (busy);
        board.note_request(r);
        requests_sent++;
    endtask

    task automatic write_pixel(input int unsigned x, input int unsigned y,
                               input logic [RAW_W-1:0] value);
        t_request r;
        r.action      = ACT_WRITE;
        r.pixel_x     = COORD_W'(x);
        r.pixel_y     = COORD_W'(y);
        r.pixel_value = value;
        r.target_x    = COORD_W'($urandom);
        r.target_y    = COORD_W'($urandom);
        r.src_x       = COORD_W'($urandom);
        r.src_y       = COORD_W'($urandom);
        send_request(r);
        pix_written[board.pixel_index(x, y)] = 1'b1;
    endtask

    // mask_odds of 0 never masks, otherwise one in mask_odds is masked
    function automatic logic [RAW_W-1:0] random_pixel_value(int unsigned mask_odds);
        logic [23:0] colour;
        colour = ($urandom_range(0, 7) == 0) ? 24'($urandom) : palette[$urandom_range(0, 3)];
        if (mask_odds != 0 && $urandom_range(1, mask_odds) == 1)
            return {8'($urandom_range(1, 255)), colour};
        return {8'h00, colour};
    endfunction

    function automatic int unsigned random_coord();
        int unsigned picks [7] = '{0, 3, 4, 5, 123, 124, 127};
        if ($urandom_range(0, 7) == 0) return picks[$urandom_range(0, 6)];
        return $urandom_range(0, 127);
    endfunction

    task automatic fill_tile(input int unsigned ax, input int unsigned ay,
                             input int unsigned mask_odds);
        for (int row = 0; row < TILE_H; row++) begin
            for (int col = 0; col < TILE_W; col++) begin
                if (!pix_written[board.pixel_index(ax + col, ay + row)])
                    write_pixel(ax + col, ay + row, random_pixel_value(mask_odds));
            end
        end
    endtask

    // every pixel of both tiles is written before the compare goes out
    task automatic run_compare(input int unsigned tx, input int unsigned ty,
                               input int unsigned sx, input int unsigned sy,
                               input bit shaped);
        t_request         r;
        int unsigned      ax;
        int unsigned      ay;
        int unsigned      bx;
        int unsigned      by;
        logic [PIX_W-1:0] e;
        ax = board.tile_corner(tx, 1'b0);
        ay = board.tile_corner(ty, 1'b1);
        bx = board.tile_corner(sx, 1'b0);
        by = board.tile_corner(sy, 1'b1);
        fill_tile(ax, ay, shaped ? 150 : 0);
        fill_tile(bx, by, shaped ? 150 : 0);
        if (shaped && $urandom_range(0, 2) == 0) begin
            for (int row = 0; row < TILE_H; row++) begin
                for (int col = 0; col < TILE_W; col++) begin
                    e = board.frame[board.pixel_index(bx + col, by + row)];
                    if (e[FLAG_BIT]) write_pixel(bx + col, by + row, {8'h00, e[23:0]});
                end
            end
        end
        if (shaped && $urandom_range(0, 4) == 0) begin
            for (int row = 0; row < TILE_H; row++) begin
                for (int col = 0; col < TILE_W; col++) begin
                    e = board.frame[board.pixel_index(bx + col, by + row)];
                    if ($urandom_range(0, 15) == 0)
                        write_pixel(ax + col, ay + row, random_pixel_value(4));
                    else
                        write_pixel(ax + col, ay + row, {7'b0, e[FLAG_BIT], e[23:0]});
                end
            end
        end
        r.action      = ACT_COMPARE;
        r.pixel_x     = COORD_W'($urandom);
        r.pixel_y     = COORD_W'($urandom);
        r.pixel_value = $urandom;
        r.target_x    = COORD_W'(tx);
        r.target_y    = COORD_W'(ty);
        r.src_x       = COORD_W'(sx);
        r.src_y       = COORD_W'(sy);
        send_request(r);
        compares_sent++;
    endtask

    task automatic write_register(input logic idx, input logic [CFG_W-1:0] data);
        @(negedge i_clk);
        start <= 1'b0;
        while (board.expected_counts.size() != 0) @(posedge i_clk);
        do @(posedge i_clk); while (busy);
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        board.set_register(idx, data);
    endtask

    task automatic set_frame(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
        write_register(CFG_FRAME_WIDTH, w);
        write_register(CFG_FRAME_HEIGHT, h);
    endtask

    task automatic random_phase(input int unsigned items, input int unsigned compares);
        int unsigned sent0;
        int unsigned cmp0;
        sent0  = requests_sent;
        cmp0   = compares_sent;
        base_x = $urandom_range(0, MAX_W - 16);
        base_y = $urandom_range(0, MAX_H - 16);
        while (requests_sent - sent0 < items || compares_sent - cmp0 < compares) begin
            case ($urandom_range(0, 9))
                0, 1: begin
                    write_pixel($urandom_range(0, 127), $urandom_range(0, 127),
                                ($urandom_range(0, 9) == 0) ? $urandom : random_pixel_value(8));
                end
                2, 3: begin
                    write_pixel(base_x + $urandom_range(0, 15), base_y + $urandom_range(0, 15),
                                random_pixel_value(8));
                end
                4: begin
                    run_compare(random_coord(), random_coord(), random_coord(), random_coord(),
                                1'b1);
                end
                default: begin
                    run_compare(base_x + $urandom_range(0, 15), base_y + $urandom_range(0, 15),
                                base_x + $urandom_range(0, 15), base_y + $urandom_range(0, 15),
                                1'b1);
                end
            endcase
        end
    endtask

    initial begin
        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        start         = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = CFG_FRAME_WIDTH;
        i_cfg_data    = '0;
        i_action      = ACT_WRITE;
        i_pixel_x     = '0;
        i_pixel_y     = '0;
        i_pixel_value = '0;
        i_target_x    = '0;
        i_target_y    = '0;
        i_src_x       = '0;
        i_src_y       = '0;
        board         = new();
        requests_sent = 0;
        compares_sent = 0;
        gapless       = 1'b0;
        palette       = '{24'h000000, 24'hFFFFFF, 24'h5A5A5A, 24'($urandom)};
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed, reset frame size
        run_compare(0, 0, 127, 127, 1'b0);
        run_compare(127, 127, 127, 127, 1'b0);
        write_pixel(127, 127, 32'hFFFF_FFFF);
        run_compare(0, 0, 127, 127, 1'b0);
        run_compare(127, 127, 0, 0, 1'b0);
        write_pixel(0, 0, 32'h00FF_FFFF);
        write_pixel(7, 7, 32'h0100_0000);
        run_compare(4, 3, 124, 123, 1'b0);
        run_compare(5, 5, 3, 4, 1'b0);
        write_pixel(0, 0, 32'h0000_0000);
        run_compare(0, 0, 0, 0, 1'b0);

        // out-of-range sizes saturate to the tile and to the store
        set_frame(8'd0, 8'd255);
        run_compare(127, 127, 0, 127, 1'b0);
        set_frame(8'd255, 8'd7);
        run_compare(127, 0, 64, 127, 1'b0);

        random_phase(50, 3);
        set_frame(8'd8, 8'd8);
        random_phase(50, 3);
        set_frame(8'd0, 8'd255);
        random_phase(50, 3);
        set_frame(8'd255, 8'd0);
        random_phase(50, 3);
        set_frame(8'($urandom_range(9, 127)), 8'($urandom_range(9, 127)));
        random_phase(50, 3);
        set_frame(8'd128, 8'd128);
        random_phase(50, 3);

        @(negedge i_clk);
        start <= 1'b0;
        while (board.expected_counts.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (board.failures == 0 && board.expected_counts.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
